[rtl/blm_pkg.sv]
// Package for the battery level monitor: request payload types, register
// indexes, level and event codes, discharge curve tables. No dependencies.
`default_nettype none
package blm_pkg;

  localparam int SUM_W   = 18;
  localparam int CNT_W   = 7;
  localparam int DVD_W   = 18;
  localparam int DSR_W   = 12;
  localparam int SEG_W   = 4;
  localparam int CURVE_N = 16;

  localparam logic [1:0] REG_DIVIDER_RATIO = 2'd0;
  localparam logic [1:0] REG_CRITICAL_PCT  = 2'd1;
  localparam logic [1:0] REG_WARNING_PCT   = 2'd2;

  localparam logic [1:0] LVL_UNKNOWN  = 2'd0;
  localparam logic [1:0] LVL_NORMAL   = 2'd1;
  localparam logic [1:0] LVL_WARNING  = 2'd2;
  localparam logic [1:0] LVL_CRITICAL = 2'd3;

  localparam logic [1:0] EVT_NONE      = 2'd0;
  localparam logic [1:0] EVT_WARNING   = 2'd1;
  localparam logic [1:0] EVT_CRITICAL  = 2'd2;
  localparam logic [1:0] EVT_RECOVERED = 2'd3;

  localparam logic [6:0] PCT_FULL  = 7'd100;
  localparam logic [6:0] PCT_EMPTY = 7'd0;

  localparam logic [12:0] CURVE_MV [CURVE_N] = '{
    13'd4200, 13'd4100, 13'd4000, 13'd3900, 13'd3850, 13'd3800, 13'd3750, 13'd3700,
    13'd3650, 13'd3600, 13'd3550, 13'd3500, 13'd3450, 13'd3400, 13'd3350, 13'd3300
  };
  localparam logic [6:0] CURVE_PCT [CURVE_N] = '{
    7'd100, 7'd95, 7'd83, 7'd71, 7'd64, 7'd56, 7'd46, 7'd36,
    7'd26, 7'd19, 7'd13, 7'd8, 7'd5, 7'd3, 7'd1, 7'd0
  };

  typedef struct packed {
    logic [11:0] sample_mv;
    logic        sample_ok;
    logic        last_in_burst;
    logic        charger_pin;
  } in_req_t;

  typedef struct packed {
    logic [14:0] scaled_mv;
    logic [6:0]  percent;
    logic        percent_known;
    logic [1:0]  level;
    logic [1:0]  event_res;
    logic        charging;
    logic        read_failed;
  } out_req_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
    logic             charging;
  } burst_t;

  typedef struct packed {
    logic [14:0] divider_ratio;
    logic [6:0]  critical_percent;
    logic [6:0]  warning_percent;
  } cfg_t;

  function automatic logic [1:0] pct_to_level(input logic known, input logic [6:0] pct,
                                              input logic [6:0] crit, input logic [6:0] warn);
    logic [1:0] lvl;
    if (!known) begin
      lvl = LVL_UNKNOWN;
    end else if (pct <= crit) begin
      lvl = LVL_CRITICAL;
    end else if (pct <= warn) begin
      lvl = LVL_WARNING;
    end else begin
      lvl = LVL_NORMAL;
    end
    return lvl;
  endfunction

endpackage
`default_nettype wire

[rtl/blm_front.sv]
// Front end: accepts sample requests and accumulates the valid ones per burst.
// Pushes one burst record on the burst end. Uses blm_pkg.
`default_nettype none
module blm_front #(
  parameter int SAMPLES_PER_READ = 16
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  blm_pkg::in_req_t        in_data,
  input  wire                     q_full,
  output logic                    q_push,
  output blm_pkg::burst_t         q_data
);

  logic [blm_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [blm_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                      take;

  assign in_stall = q_full;
  assign take     = in_valid && !q_full;

  always_comb begin
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    if (in_data.sample_ok && (cnt_r < blm_pkg::CNT_W'(SAMPLES_PER_READ))) begin
      sum_nxt = sum_r + blm_pkg::SUM_W'(in_data.sample_mv);
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  assign q_push          = take && in_data.last_in_burst;
  assign q_data.sum      = sum_nxt;
  assign q_data.count    = cnt_nxt;
  assign q_data.charging = !in_data.charger_pin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else if (take) begin
      if (in_data.last_in_burst) begin
        sum_r <= '0;
        cnt_r <= '0;
      end else begin
        sum_r <= sum_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/blm_fifo.sv]
// Two-entry queue of burst records between front and back end.
// Uses blm_pkg.
`default_nettype none
module blm_fifo (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  blm_pkg::burst_t  push_data,
  input  wire              pop,
  output blm_pkg::burst_t  head,
  output logic             full,
  output logic             empty
);

  blm_pkg::burst_t mem_r [2];
  logic            wr_ptr_r, rd_ptr_r;
  logic [1:0]      cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full && !pop |-> !push) else $error("push into full burst queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop) else $error("pop from empty burst queue");
`endif

endmodule
`default_nettype wire

[rtl/blm_div.sv]
// Restoring divider, one quotient bit per cycle, shared by the average and
// the curve interpolation. Uses blm_pkg.
`default_nettype none
module blm_div (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       start,
  input  wire [blm_pkg::DVD_W-1:0]  dividend,
  input  wire [blm_pkg::DSR_W-1:0]  divisor,
  output logic                      done,
  output logic [blm_pkg::DVD_W-1:0] quotient
);

  localparam int CW = $clog2(blm_pkg::DVD_W);

  logic                      busy_r, done_r;
  logic [CW-1:0]             cnt_r;
  logic [blm_pkg::DVD_W-1:0] quo_r;
  logic [blm_pkg::DSR_W-1:0] rem_r, dsr_r, rem_step;
  logic [blm_pkg::DSR_W:0]   shifted;
  logic                      ge;

  assign shifted  = {rem_r, quo_r[blm_pkg::DVD_W-1]};
  assign ge       = (shifted >= {1'b0, dsr_r});
  assign rem_step = ge ? blm_pkg::DSR_W'(shifted - {1'b0, dsr_r})
                       : shifted[blm_pkg::DSR_W-1:0];
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[blm_pkg::DVD_W-2:0], ge};
      rem_r <= rem_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(blm_pkg::DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider restarted while busy");
`endif

endmodule
`default_nettype wire

[rtl/blm_back.sv]
// Back end: per burst record computes average, scaled voltage, curve percent,
// level and event, and holds the result register. Uses blm_pkg, blm_div.
`default_nettype none
module blm_back #(
  parameter int CURVE_POINTS = 16
) (
  input  wire               clk,
  input  wire               rst_n,
  input  blm_pkg::cfg_t     cfg,
  input  wire               q_empty,
  input  blm_pkg::burst_t   q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  wire               out_stall,
  output blm_pkg::out_req_t out_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_AVG  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_SEG  = 3'd3;
  localparam logic [2:0] S_NUM  = 3'd4;
  localparam logic [2:0] S_IDIV = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]                state_r, state_nxt;
  logic                      charging_r, failed_r;
  logic [11:0]               avg_r;
  logic [14:0]               mv_r;
  logic [blm_pkg::SEG_W-1:0] seg_r, seg_idx;
  logic [6:0]                pl_r, pct_r;
  logic [6:0]                held_pct_r;
  logic                      held_known_r;
  logic                      out_valid_r;
  blm_pkg::out_req_t         out_data_r;

  logic                      div_start, div_done;
  logic [blm_pkg::DVD_W-1:0] div_dividend, div_quo;
  logic [blm_pkg::DSR_W-1:0] div_divisor;
  logic [26:0]               scaled;
  logic                      seg_hit, clamp_hi, clamp_lo;
  logic [12:0]               vh, vl;
  logic [6:0]                ph, pl, dpct;
  logic [11:0]               dmv, den;
  logic [18:0]               num;
  logic                      out_free, fin;
  logic [1:0]                lvl_old, lvl_new, evt;

  assign q_pop    = (state_r == S_IDLE) && !q_empty;
  assign out_free = !out_valid_r || !out_stall;
  assign fin      = (state_r == S_FIN) && out_free;

  assign scaled = 27'(avg_r) * 27'(cfg.divider_ratio);

  assign clamp_hi = (mv_r >= 15'(blm_pkg::CURVE_MV[0]));
  assign clamp_lo = (mv_r <= 15'(blm_pkg::CURVE_MV[CURVE_POINTS-1]));

  always_comb begin
    seg_hit = 1'b0;
    seg_idx = '0;
    for (int i = CURVE_POINTS - 2; i >= 0; i--) begin
      if ((mv_r <= 15'(blm_pkg::CURVE_MV[i])) && (mv_r >= 15'(blm_pkg::CURVE_MV[i+1]))) begin
        seg_hit = 1'b1;
        seg_idx = blm_pkg::SEG_W'(i);
      end
    end
  end

  assign vh   = blm_pkg::CURVE_MV[seg_r];
  assign vl   = blm_pkg::CURVE_MV[seg_r + 1'b1];
  assign ph   = blm_pkg::CURVE_PCT[seg_r];
  assign pl   = blm_pkg::CURVE_PCT[seg_r + 1'b1];
  assign dpct = ph - pl;
  assign dmv  = 12'(mv_r - 15'(vl));
  assign den  = 12'(vh - vl);
  assign num  = 19'(dpct) * 19'(dmv);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = q_head.sum;
    div_divisor  = blm_pkg::DSR_W'(q_head.count);
    if (q_pop && (q_head.count != '0)) begin
      div_start = 1'b1;
    end else if ((state_r == S_NUM) && (den != '0)) begin
      div_start    = 1'b1;
      div_dividend = num[blm_pkg::DVD_W-1:0];
      div_divisor  = den;
    end
  end

  blm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (q_pop) state_nxt = (q_head.count == '0) ? S_FIN : S_AVG;
      S_AVG:  if (div_done) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_SEG;
      S_SEG:  state_nxt = (clamp_hi || clamp_lo || !seg_hit) ? S_FIN : S_NUM;
      S_NUM:  state_nxt = (den == '0) ? S_FIN : S_IDIV;
      S_IDIV: if (div_done) state_nxt = S_FIN;
      S_FIN:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (q_pop) begin
          charging_r <= q_head.charging;
          failed_r   <= (q_head.count == '0);
          mv_r       <= '0;
        end
      end
      S_AVG:  if (div_done) avg_r <= div_quo[11:0];
      S_MUL:  mv_r <= scaled[26:12];
      S_SEG: begin
        seg_r <= seg_idx;
        pct_r <= clamp_hi ? blm_pkg::PCT_FULL : blm_pkg::PCT_EMPTY;
      end
      S_NUM: begin
        pl_r  <= pl;
        pct_r <= pl;
      end
      S_IDIV: if (div_done) pct_r <= pl_r + div_quo[6:0];
      default: ;
    endcase
  end

  always_comb begin
    lvl_old = blm_pkg::pct_to_level(held_known_r, held_pct_r,
                                    cfg.critical_percent, cfg.warning_percent);
    lvl_new = blm_pkg::pct_to_level(1'b1, pct_r, cfg.critical_percent, cfg.warning_percent);
    evt     = blm_pkg::EVT_NONE;
    if (lvl_new != lvl_old) begin
      case (lvl_new)
        blm_pkg::LVL_WARNING:  evt = blm_pkg::EVT_WARNING;
        blm_pkg::LVL_CRITICAL: evt = blm_pkg::EVT_CRITICAL;
        blm_pkg::LVL_NORMAL:   if (lvl_old != blm_pkg::LVL_UNKNOWN) evt = blm_pkg::EVT_RECOVERED;
        default: evt = blm_pkg::EVT_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      out_data_r.scaled_mv   <= mv_r;
      out_data_r.charging    <= charging_r;
      out_data_r.read_failed <= failed_r;
      if (failed_r) begin
        out_data_r.percent       <= held_pct_r;
        out_data_r.percent_known <= held_known_r;
        out_data_r.level         <= lvl_old;
        out_data_r.event_res     <= blm_pkg::EVT_NONE;
      end else begin
        out_data_r.percent       <= pct_r;
        out_data_r.percent_known <= 1'b1;
        out_data_r.level         <= lvl_new;
        out_data_r.event_res     <= evt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      held_pct_r   <= '0;
      held_known_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fin) begin
        out_valid_r <= 1'b1;
        if (!failed_r) begin
          held_pct_r   <= pct_r;
          held_known_r <= 1'b1;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == S_AVG) || (state_r == S_FIN)) else $error("bad pop sequencing");
  a_known_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    held_known_r |=> held_known_r) else $error("held percent lost");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> $stable(out_data_r)) else $error("result overwritten");
`endif

endmodule
`default_nettype wire

[rtl/battery_level_monitor_top.sv]
// Top level of the battery level monitor: config registers, front end,
// burst queue and back end. Uses blm_pkg, blm_front, blm_fifo, blm_back.
//
//   channel | direction | handshake        | payload
//   in_     | input     | in_valid/stall   | blm_pkg::in_req_t
//   out_    | output    | out_valid/stall  | blm_pkg::out_req_t
//   cfg_    | input     | cfg_valid/ready  | cfg_index, cfg_data
//
// Samples are taken one per cycle while in_stall is low; the back end handles a
// burst end with up to two 18-step passes through the shared divider.
// A voltage off the curve span skips the second pass; a failed burst (no
// valid sample) skips both passes.
// Reset is synchronous, active low; control and config registers return to defaults.
// in_stall rises only when the two-entry burst queue is full.
`default_nettype none
module battery_level_monitor_top #(
  parameter int SAMPLES_PER_READ = 16,
  parameter int CURVE_POINTS     = 16
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  input  blm_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  wire               out_stall,
  output blm_pkg::out_req_t out_data,
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire [1:0]         cfg_index,
  input  wire [14:0]        cfg_data
);

  blm_pkg::cfg_t   cfg_r;
  blm_pkg::burst_t push_data, head;
  logic            push, pop, full, empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.divider_ratio    <= 15'd8192;
      cfg_r.critical_percent <= 7'd10;
      cfg_r.warning_percent  <= 7'd20;
    end else if (cfg_valid) begin
      case (cfg_index)
        blm_pkg::REG_DIVIDER_RATIO: cfg_r.divider_ratio    <= cfg_data;
        blm_pkg::REG_CRITICAL_PCT:  cfg_r.critical_percent <= cfg_data[6:0];
        blm_pkg::REG_WARNING_PCT:   cfg_r.warning_percent  <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  blm_front #(.SAMPLES_PER_READ(SAMPLES_PER_READ)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (full),
    .q_push   (push),
    .q_data   (push_data)
  );

  blm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (full),
    .empty     (empty)
  );

  blm_back #(.CURVE_POINTS(CURVE_POINTS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (empty),
    .q_head    (head),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Testbench for battery_level_monitor_top: directed and random sample bursts
// checked against an in-file predictor. Depends on blm_pkg and the RTL top.
module testbench;

  localparam int SAMPLES_PER_READ = 16;
  localparam int DRAIN_CYCLES     = 60;
  localparam int WATCHDOG_LIMIT   = 4000;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  blm_pkg::in_req_t  in_data;
  logic              out_valid;
  logic              out_stall = 1'b0;
  blm_pkg::out_req_t out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [14:0] cfg_data;

  battery_level_monitor_top #(
    .SAMPLES_PER_READ(SAMPLES_PER_READ),
    .CURVE_POINTS(blm_pkg::CURVE_N)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predictor state and register copies
  logic [14:0] div_ratio;
  logic [6:0]  crit_pct;
  logic [6:0]  warn_pct;
  logic [17:0] acc_sum;
  logic [6:0]  acc_count;
  logic [6:0]  held_pct;
  logic        held_known;

  blm_pkg::out_req_t expected_readings[$];

  bit idle_on;
  int mismatches;
  int readings_checked;
  int failed_reads;
  int level_events;
  int settings_used;
  int samples_sent;
  int stall_left = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [6:0] curve_percent(int unsigned mv);
    int unsigned vh, vl, ph, pl;
    logic [6:0] pct;
    bit found;
    pct = blm_pkg::PCT_EMPTY;
    found = 1'b0;
    if (mv >= blm_pkg::CURVE_MV[0]) begin
      pct = blm_pkg::PCT_FULL;
    end else if (mv > blm_pkg::CURVE_MV[blm_pkg::CURVE_N-1]) begin
      for (int i = 0; i < blm_pkg::CURVE_N - 1; i++) begin
        vh = blm_pkg::CURVE_MV[i];
        vl = blm_pkg::CURVE_MV[i+1];
        if (!found && mv <= vh && mv >= vl) begin
          ph = blm_pkg::CURVE_PCT[i];
          pl = blm_pkg::CURVE_PCT[i+1];
          found = 1'b1;
          if (vh == vl) pct = 7'(pl);
          else pct = 7'(pl + ((ph - pl) * (mv - vl)) / (vh - vl));
        end
      end
    end
    return pct;
  endfunction

  function automatic logic [1:0] level_of(logic known, logic [6:0] pct);
    if (!known) return blm_pkg::LVL_UNKNOWN;
    if (pct <= crit_pct) return blm_pkg::LVL_CRITICAL;
    if (pct <= warn_pct) return blm_pkg::LVL_WARNING;
    return blm_pkg::LVL_NORMAL;
  endfunction

  function automatic void absorb_sample(blm_pkg::in_req_t s);
    blm_pkg::out_req_t r;
    int unsigned avg;
    int unsigned scaled;
    logic [1:0] prev;
    if (s.sample_ok && acc_count < SAMPLES_PER_READ) begin
      acc_sum = acc_sum + 18'(s.sample_mv);
      acc_count = acc_count + 7'd1;
    end
    if (!s.last_in_burst) return;
    r = '0;
    r.event_res = blm_pkg::EVT_NONE;
    r.charging = !s.charger_pin;
    if (acc_count == 0) begin
      r.read_failed = 1'b1;
      r.percent = held_pct;
      r.percent_known = held_known;
      r.level = level_of(held_known, held_pct);
      failed_reads++;
    end else begin
      avg = acc_sum / acc_count;
      prev = level_of(held_known, held_pct);
      scaled = (avg * div_ratio) >> 12;
      r.scaled_mv = 15'(scaled);
      r.percent = curve_percent(r.scaled_mv);
      r.percent_known = 1'b1;
      r.level = level_of(1'b1, r.percent);
      if (r.level != prev) begin
        if (r.level == blm_pkg::LVL_WARNING) r.event_res = blm_pkg::EVT_WARNING;
        else if (r.level == blm_pkg::LVL_CRITICAL) r.event_res = blm_pkg::EVT_CRITICAL;
        else if (r.level == blm_pkg::LVL_NORMAL && prev != blm_pkg::LVL_UNKNOWN)
          r.event_res = blm_pkg::EVT_RECOVERED;
      end
      if (r.event_res != blm_pkg::EVT_NONE) level_events++;
      held_pct = r.percent;
      held_known = 1'b1;
    end
    acc_sum = '0;
    acc_count = '0;
    expected_readings.push_back(r);
  endfunction

  // valid stays high between back-to-back requests; callers lower it before waiting
  task automatic send_sample(blm_pkg::in_req_t item);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    absorb_sample(item);
    samples_sent++;
  endtask

  task automatic send_fields(logic [11:0] mv, logic ok, logic last, logic pin);
    blm_pkg::in_req_t item;
    item.sample_mv = mv;
    item.sample_ok = ok;
    item.last_in_burst = last;
    item.charger_pin = pin;
    send_sample(item);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_readings.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [14:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      blm_pkg::REG_DIVIDER_RATIO: div_ratio = value;
      blm_pkg::REG_CRITICAL_PCT: crit_pct = value[6:0];
      blm_pkg::REG_WARNING_PCT: warn_pct = value[6:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(logic [14:0] ratio, logic [6:0] crit, logic [6:0] warn);
    wait_drain();
    write_reg(blm_pkg::REG_DIVIDER_RATIO, ratio);
    write_reg(blm_pkg::REG_CRITICAL_PCT, 15'(crit));
    write_reg(blm_pkg::REG_WARNING_PCT, 15'(warn));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // bursts aimed mostly at the curve span after divider scaling
  task automatic run_bursts(int n_items);
    int sent, len, target, base, mv;
    bit all_bad;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 16);
      all_bad = ($urandom_range(0, 14) == 0);
      target = $urandom_range(3200, 4300);
      if (div_ratio == 0) base = $urandom_range(0, 4095);
      else base = (target * 4096) / div_ratio;
      if (base > 4095) base = 4095;
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          mv = $urandom_range(0, 4095);
        end else begin
          mv = base + $urandom_range(0, 40) - 20;
          if (mv < 0) mv = 0;
          if (mv > 4095) mv = 4095;
        end
        send_fields(12'(mv), all_bad ? 1'b0 : ($urandom_range(0, 9) != 0),
                    k == len - 1, 1'($urandom_range(0, 1)));
      end
      sent += len;
    end
  endtask

  task automatic test_failed_read_unknown();
    send_fields(12'd2100, 1'b0, 1'b1, 1'b0);
  endtask

  task automatic test_curve_points();
    send_fields(12'd2100, 1'b1, 1'b1, 1'b1);
    send_fields(12'd1650, 1'b1, 1'b1, 1'b0);
    send_fields(12'd4095, 1'b1, 1'b1, 1'b1);
    send_fields(12'd1800, 1'b1, 1'b1, 1'b0);
    send_fields(12'd0, 1'b1, 1'b1, 1'b1);
    send_fields(12'd1975, 1'b1, 1'b1, 1'b0);
    send_fields(12'd4095, 1'b0, 1'b1, 1'b1);
  endtask

  task automatic test_sample_cap();
    for (int k = 0; k < SAMPLES_PER_READ; k++) send_fields(12'd1800, 1'b1, 1'b0, 1'(k));
    send_fields(12'd4095, 1'b1, 1'b1, 1'b0);
  endtask

  task automatic test_threshold_settings();
    run_bursts(40);
    wait_drain();
    run_bursts(40);
    apply_setting(15'd0, 7'd0, 7'd0);
    run_bursts(70);
    apply_setting(15'd32767, 7'd100, 7'd100);
    run_bursts(70);
    apply_setting(15'd4096, 7'd60, 7'd30);
    run_bursts(70);
    apply_setting(15'd12288, 7'd30, 7'd70);
    run_bursts(70);
    apply_setting(15'($urandom_range(4096, 16384)), 7'($urandom_range(0, 100)),
                  7'($urandom_range(0, 100)));
    run_bursts(70);
  endtask

  task automatic test_back_to_back();
    apply_setting(15'd8192, 7'd10, 7'd20);
    idle_on = 1'b0;
    run_bursts(60);
    idle_on = 1'b1;
  endtask

  always @(posedge clk) begin
    if (!rst_n || !idle_on) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_stall <= 1'b1;
      stall_left <= pick_gap();
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    blm_pkg::out_req_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", out_data);
      end else begin
        want = expected_readings.pop_front();
        readings_checked++;
        if (out_data.scaled_mv !== want.scaled_mv || out_data.percent !== want.percent ||
            out_data.percent_known !== want.percent_known || out_data.level !== want.level ||
            out_data.event_res !== want.event_res || out_data.charging !== want.charging ||
            out_data.read_failed !== want.read_failed) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, out_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    idle_on = 1'b0;
    mismatches = 0;
    readings_checked = 0;
    failed_reads = 0;
    level_events = 0;
    settings_used = 0;
    samples_sent = 0;
    div_ratio = 15'd8192;
    crit_pct = 7'd10;
    warn_pct = 7'd20;
    acc_sum = '0;
    acc_count = '0;
    held_pct = '0;
    held_known = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_failed_read_unknown();
    test_curve_points();
    test_sample_cap();
    idle_on = 1'b1;
    test_threshold_settings();
    test_back_to_back();
    wait_drain();

    $display("%0d samples sent, %0d readings checked (%0d failed reads, %0d level events)",
             samples_sent, readings_checked, failed_reads, level_events);
    $display("%0d register settings applied, %0d mismatches", settings_used, mismatches);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
